// ===== rtl/gb3_pkg.sv =====
// Shared types and constants for the 3x3 Gaussian blur accumulator.
// Used by the top level and the tap pipeline; depends on nothing else.
`timescale 1ns / 1ps

package gb3_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_PIXEL_BITS = 16;

   localparam int NUM_TAPS       = 9;
   localparam int SIZE_BITS      = 11;
   localparam int WEIGHT_BITS    = 16;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam int                     SIZE_RESET   = 64;
   localparam logic [WEIGHT_BITS-1:0] CORNER_RESET = 16'd6209;
   localparam logic [WEIGHT_BITS-1:0] EDGE_RESET   = 16'd7754;
   localparam logic [WEIGHT_BITS-1:0] CENTER_RESET = 16'd9684;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_SIZE    = 2'd0,
      REG_CORNER_WEIGHT = 2'd1,
      REG_EDGE_WEIGHT   = 2'd2,
      REG_CENTER_WEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   // per-item control that rides along with the tap operands
   typedef struct packed {
      logic [NUM_TAPS-1:0] tap_on;
      logic                last;
   } tap_ctrl_type;

endpackage

// ===== rtl/gb3_ram.sv =====
// Single-port-write, single-port-read memory with registered, write-first read.
// Generic storage for line and delay buffers; no package dependency.
`timescale 1ns / 1ps

module gb3_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-address write in this cycle wins over the stored word
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gb3_tap_pipe.sv =====
// Multiply and nine-step accumulate pipeline for the blur taps.
// Depends on gb3_pkg for tap count, weight format and the control struct.
`timescale 1ns / 1ps

module gb3_tap_pipe #(
   parameter int PIXEL_BITS = gb3_pkg::DEFAULT_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [PIXEL_BITS-1:0]        in_px [gb3_pkg::NUM_TAPS],
   input  logic signed [PIXEL_BITS-1:0]        in_base,
   input  gb3_pkg::tap_ctrl_type               in_ctrl,
   input  logic [gb3_pkg::WEIGHT_BITS-1:0]     corner_weight,
   input  logic [gb3_pkg::WEIGHT_BITS-1:0]     edge_weight,
   input  logic [gb3_pkg::WEIGHT_BITS-1:0]     center_weight,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [PIXEL_BITS-1:0]        out_data,
   output logic                                out_last
);

   import gb3_pkg::*;

   localparam int PB   = PIXEL_BITS;
   localparam int PRW  = PB + WEIGHT_BITS + 1;
   localparam int SUMW = PB + FRAC_BITS + 2;
   localparam int QW   = SUMW - FRAC_BITS;
   // stage 0: operands, stage 1: products, stages 2..NS-1: one tap each
   localparam int NS   = NUM_TAPS + 2;

   localparam logic signed [QW-1:0] SAT_HI = {{(QW-PB+1){1'b0}}, {(PB-1){1'b1}}};
   localparam logic signed [QW-1:0] SAT_LO = {{(QW-PB+1){1'b1}}, {(PB-1){1'b0}}};
   localparam logic signed [QW-1:0] ONE_Q  = 1;

   function automatic logic signed [PB-1:0] tap_step(
      input logic signed [PB-1:0]  acc,
      input logic signed [PRW-1:0] prod
   );
      logic signed [SUMW-1:0] sum;
      logic signed [QW-1:0]   q;
      sum = (SUMW'(acc) <<< FRAC_BITS) + SUMW'(prod);
      q   = sum[SUMW-1:FRAC_BITS];
      // arithmetic shift floors; round negatives with a remainder toward zero
      if (sum[SUMW-1] && (sum[FRAC_BITS-1:0] != '0)) begin
         q = q + ONE_Q;
      end
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return PB'(q);
   endfunction

   logic [NS-1:0]              vld_ff;
   logic [NS-1:0]              en;

   logic signed [PB-1:0]       px0_ff [NUM_TAPS];
   logic signed [PB-1:0]       base0_ff;
   tap_ctrl_type               ctrl0_ff;

   logic signed [PRW-1:0]      prod_w  [NUM_TAPS];
   logic signed [PRW-1:0]      prod_ff [1:NS-2][NUM_TAPS];
   logic signed [PB-1:0]       acc_ff  [1:NS-1];
   logic                       last_ff [1:NS-1];

   // a stage takes new data when it is empty or its successor moves on
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         px0_ff   <= in_px;
         base0_ff <= in_base;
         ctrl0_ff <= in_ctrl;
      end
   end

   for (genvar t = 0; t < NUM_TAPS; t++) begin : g_mul
      localparam int C = t / 3;
      localparam int R = t % 3;
      logic [WEIGHT_BITS-1:0] wt;
      if (C == 1 && R == 1) begin : g_center
         assign wt = center_weight;
      end else if (C == 1 || R == 1) begin : g_edge
         assign wt = edge_weight;
      end else begin : g_corner
         assign wt = corner_weight;
      end
      assign prod_w[t] = $signed({1'b0, wt}) * px0_ff[t];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int t = 0; t < NUM_TAPS; t++) begin
            // a masked tap adds nothing, which leaves the running value as is
            prod_ff[1][t] <= ctrl0_ff.tap_on[t] ? prod_w[t] : '0;
         end
         acc_ff[1]  <= base0_ff;
         last_ff[1] <= ctrl0_ff.last;
      end
   end

   for (genvar k = 2; k < NS; k++) begin : g_tap
      always_ff @(posedge clock) begin
         if (en[k]) begin
            acc_ff[k]  <= tap_step(acc_ff[k-1], prod_ff[k-1][k-2]);
            last_ff[k] <= last_ff[k-1];
         end
      end
      if (k < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[k]) begin
               prod_ff[k] <= prod_ff[k-1];
            end
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_data  = acc_ff[NS-1];
   assign out_last  = last_ff[NS-1];

endmodule

// ===== rtl/gaussian_blur_3x3_accumulate.sv =====
// Top level of the streaming 3x3 Gaussian blur accumulator.
// Depends on gb3_pkg, gb3_ram (line and base delay stores) and gb3_tap_pipe.
`timescale 1ns / 1ps

// Usage:
//  req_* carries one item per handshake: a pixel and its base value, with
//  req_tuser marking a pixel item or a flush item. rsp_* returns the base
//  value plus the weighted 3x3 neighborhood, saturated; rsp_tlast flags the
//  final pixel of the image. csr_* writes image size and the three Q0.16
//  weights, and is always ready; write only while the block is idle.
//  The result for pixel m is caused by the item h+1 positions later (h =
//  image size), so h+1 flush items drain the end of an image.
//  Throughput: one item per cycle while rsp_tready does not stall the
//  pipeline. The line stores are single-write, registered-read memories
//  read ahead at the next column, and the nine taps run as a pipeline of
//  one multiply stage and nine add/round/clamp stages. The causing item's
//  result passes one operand, one product and nine tap registers to rsp.
//  A stalled rsp_tready holds the result in the output register; the
//  pipeline keeps accepting until its empty slots are used up.
//  Reset: synchronous; counters, window and valid bits clear, registers
//  return to size 64 and the default weights. No clearing pass is needed:
//  unwritten store entries are always masked at the image borders.

module gaussian_blur_3x3_accumulate #(
   parameter int MAX_WIDTH  = gb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int PIXEL_BITS = gb3_pkg::DEFAULT_PIXEL_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [PB-1:0] pixel, [2*PB-1:PB] base_value, zero padded to bytes
   input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]      req_tdata,
   // [0] opcode
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [PB-1:0] blurred, zero padded to bytes
   output logic [((PIXEL_BITS+7)/8)*8-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gb3_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [gb3_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   import gb3_pkg::*;

   localparam int PB      = PIXEL_BITS;
   localparam int RSP_W   = ((PIXEL_BITS + 7) / 8) * 8;
   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int HW      = $clog2(MAX_WIDTH + 1);
   localparam int YW      = $clog2(MAX_WIDTH + 2);
   localparam int H_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;

   // configuration
   logic [HW-1:0]          h_ff;
   logic [XW-1:0]          hm1_ff;
   logic [HW-1:0]          h_new;
   logic [XW-1:0]          hm1_new;
   logic [SIZE_BITS-1:0]   size_req;
   logic [WEIGHT_BITS-1:0] corner_ff;
   logic [WEIGHT_BITS-1:0] edge_ff;
   logic [WEIGHT_BITS-1:0] center_ff;
   logic                   size_wr;

   // stream position
   logic [XW-1:0]          x_ff, x_in;
   logic [YW-1:0]          y_ff, y_in;
   logic [HW-1:0]          slot_ff, slot_in;
   logic [XW-1:0]          ox_ff, ox_in;
   logic [XW-1:0]          oy_ff, oy_in;
   logic signed [PB-1:0]   win_ff  [3][3];
   logic signed [PB-1:0]   win_in  [3][3];
   logic signed [PB-1:0]   win_new [3][3];

   logic                   accept;
   logic                   emit;
   logic                   last;
   logic                   up, dn, lf, rt;
   logic signed [PB-1:0]   req_pixel;
   logic signed [PB-1:0]   req_base;
   logic signed [PB-1:0]   p_val;

   logic [2*PB-1:0]        row_rd;
   logic signed [PB-1:0]   row_a_rd;
   logic signed [PB-1:0]   row_b_rd;
   logic [PB-1:0]          base_rd;

   logic signed [PB-1:0]   tap_px [NUM_TAPS];
   tap_ctrl_type           tap_ctrl;
   logic                   pipe_ready;
   logic signed [PB-1:0]   pipe_data;

   assign csr_ready = 1'b1;
   assign size_wr   = csr_valid && csr_ready && (csr_index == REG_IMAGE_SIZE);
   assign size_req  = csr_data[SIZE_BITS-1:0];

   always_comb begin
      if (size_req == '0) begin
         h_new = HW'(1);
      end else if (32'(size_req) > 32'(MAX_WIDTH)) begin
         h_new = HW'(MAX_WIDTH);
      end else begin
         h_new = HW'(size_req);
      end
      hm1_new = XW'(h_new - HW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff      <= HW'(H_RESET);
         hm1_ff    <= XW'(H_RESET - 1);
         corner_ff <= CORNER_RESET;
         edge_ff   <= EDGE_RESET;
         center_ff <= CENTER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_SIZE: begin
               h_ff   <= h_new;
               hm1_ff <= hm1_new;
            end
            REG_CORNER_WEIGHT: corner_ff <= csr_data[WEIGHT_BITS-1:0];
            REG_EDGE_WEIGHT:   edge_ff   <= csr_data[WEIGHT_BITS-1:0];
            REG_CENTER_WEIGHT: center_ff <= csr_data[WEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = pipe_ready;
   assign accept     = req_tvalid && req_tready;
   assign req_pixel  = req_tdata[PB-1:0];
   assign req_base   = req_tdata[2*PB-1:PB];
   assign row_a_rd   = row_rd[2*PB-1:PB];
   assign row_b_rd   = row_rd[PB-1:0];

   // rows past the image (and flush items) feed zeros into the window
   assign p_val = ((req_tuser == OP_PIXEL) && (y_ff < YW'(h_ff))) ? req_pixel : '0;

   // a result is due once h+1 items of this image have gone in
   assign emit = (y_ff > YW'(1)) || ((y_ff == YW'(1)) && (x_ff != '0));
   assign last = (ox_ff == hm1_ff) && (oy_ff == hm1_ff);
   assign up   = (oy_ff != '0);
   assign dn   = (oy_ff != hm1_ff);
   assign lf   = (ox_ff != '0);
   assign rt   = (ox_ff != hm1_ff);

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_new[r][0] = win_ff[r][1];
         win_new[r][1] = win_ff[r][2];
      end
      win_new[0][2] = row_b_rd;
      win_new[1][2] = row_a_rd;
      win_new[2][2] = p_val;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      slot_in = slot_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      win_in  = win_ff;
      if (accept) begin
         win_in = win_new;
         if (x_ff == hm1_ff) begin
            x_in = '0;
            y_in = y_ff + YW'(1);
         end else begin
            x_in = x_ff + XW'(1);
         end
         slot_in = (slot_ff == h_ff) ? '0 : slot_ff + HW'(1);
         if (emit) begin
            if (ox_ff == hm1_ff) begin
               ox_in = '0;
               oy_in = oy_ff + XW'(1);
            end else begin
               ox_in = ox_ff + XW'(1);
            end
         end
      end
      // end of image or a new size: start over at the first pixel
      if ((accept && emit && last) || size_wr) begin
         x_in    = '0;
         y_in    = '0;
         slot_in = '0;
         ox_in   = '0;
         oy_in   = '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_in[r][c] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         slot_ff <= '0;
         ox_ff   <= '0;
         oy_ff   <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         slot_ff <= slot_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         win_ff  <= win_in;
      end
   end

   // both line stores share one word: upper half is the previous row,
   // lower half the row before it; reads run one column ahead
   gb3_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (2 * PB)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (x_ff),
      .wr_data ({p_val, row_a_rd}),
      .rd_addr (x_in),
      .rd_data (row_rd)
   );

   // base values wait h+1 items in a circular buffer
   gb3_ram #(
      .DEPTH (MAX_WIDTH + 1),
      .WIDTH (PB)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_base),
      .rd_addr (slot_in),
      .rd_data (base_rd)
   );

   // taps in column order of the window, left column first
   for (genvar t = 0; t < NUM_TAPS; t++) begin : g_taps
      localparam int C = t / 3;
      localparam int R = t % 3;
      logic col_on;
      logic row_on;
      if (C == 0) begin : g_left
         assign col_on = lf;
      end else if (C == 2) begin : g_right
         assign col_on = rt;
      end else begin : g_mid_col
         assign col_on = 1'b1;
      end
      if (R == 0) begin : g_up
         assign row_on = up;
      end else if (R == 2) begin : g_down
         assign row_on = dn;
      end else begin : g_mid_row
         assign row_on = 1'b1;
      end
      assign tap_px[t]          = win_new[R][C];
      assign tap_ctrl.tap_on[t] = col_on && row_on;
   end

   assign tap_ctrl.last = last;

   gb3_tap_pipe #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_tap_pipe (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid && emit),
      .in_ready      (pipe_ready),
      .in_px         (tap_px),
      .in_base       ($signed(base_rd)),
      .in_ctrl       (tap_ctrl),
      .corner_weight (corner_ff),
      .edge_weight   (edge_ff),
      .center_weight (center_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (pipe_data),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'($unsigned(pipe_data));

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      x_ff <= hm1_ff)
      else $error("column counter beyond image width");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= h_ff)
      else $error("base delay slot beyond image width");

   a_out_lag: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && (x_ff != '0)) |->
         ((ox_ff + XW'(1)) == x_ff) && ((YW'(oy_ff) + YW'(1)) == y_ff))
      else $error("output position does not lag input by one row plus one");

endmodule

// ===== verif/blur_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 3x3 blur accumulator: tracks CSR writes and input items, predicts each
// blurred result, and compares it field by field with what leaves rsp_*.
// Depends on gb3_pkg only.

module blur_checker #(
   parameter int MAX_W = gb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int PB    = gb3_pkg::DEFAULT_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // [PB-1:0] pixel, [2*PB-1:PB] base_value
   input  logic [((2*PB+7)/8)*8-1:0]           req_tdata,
   // [0] opcode
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [PB-1:0] blurred
   input  logic [((PB+7)/8)*8-1:0]             rsp_tdata,
   input  logic                                rsp_tlast,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [gb3_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gb3_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  checked
);
   import gb3_pkg::*;

   localparam longint Q_ONE   = 64'sd1 << FRAC_BITS;
   localparam longint PIX_MAX = (64'sd1 <<< (PB - 1)) - 1;
   localparam longint PIX_MIN = -PIX_MAX - 1;

   typedef struct packed {
      logic signed [PB-1:0] blurred;
      logic                 last_pixel;
   } blur_expect_type;

   blur_expect_type expected_blur[$];

   logic [SIZE_BITS-1:0]   size_reg;
   logic [WEIGHT_BITS-1:0] corner_w, edge_w, center_w;

   // line above the current one, the line two above, and the delayed base values
   logic signed [PB-1:0] line_prev  [MAX_W];
   logic signed [PB-1:0] line_prev2 [MAX_W];
   logic signed [PB-1:0] base_line  [MAX_W+1];
   logic signed [PB-1:0] win [9];
   int unsigned          col, row;

   function void restart_frame();
      col = 0;
      row = 0;
      for (int i = 0; i < 9; i++) win[i] = '0;
   endfunction

   // one tap: add weight*pixel in Q0.16, truncate toward zero, clamp
   function automatic logic signed [PB-1:0] blur_tap(input logic signed [PB-1:0] acc,
                                                     input logic [WEIGHT_BITS-1:0] weight,
                                                     input logic signed [PB-1:0] pix,
                                                     input bit on);
      longint sum;
      if (!on) return acc;
      sum = (longint'(acc) * Q_ONE + longint'(weight) * longint'(pix)) / Q_ONE;
      if (sum > PIX_MAX) return PIX_MAX[PB-1:0];
      if (sum < PIX_MIN) return PIX_MIN[PB-1:0];
      return sum[PB-1:0];
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   always @(posedge clock) begin : predict
      int unsigned          h, x, y, n, slot, m, mr, mc;
      logic signed [PB-1:0] pix, base_in, acc;
      bit                   up, dn, lf, rt, last;
      blur_expect_type      want;

      if (reset) begin
         size_reg = SIZE_BITS'(SIZE_RESET);
         corner_w = CORNER_RESET;
         edge_w   = EDGE_RESET;
         center_w = CENTER_RESET;
         restart_frame();
         expected_blur.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMAGE_SIZE: begin
                  size_reg = csr_data[SIZE_BITS-1:0];
                  restart_frame();
               end
               REG_CORNER_WEIGHT: corner_w = csr_data;
               REG_EDGE_WEIGHT:   edge_w   = csr_data;
               REG_CENTER_WEIGHT: center_w = csr_data;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            h = (size_reg == 0) ? 1 : ((size_reg > MAX_W) ? MAX_W : size_reg);
            x = col;
            y = row;
            if (x >= h || y > h + 1) begin
               restart_frame();
               x = 0;
               y = 0;
            end
            n = y * h + x;
            // flush inside the image counts as a zero pixel; pixels past the end are ignored
            pix = (req_tuser == OP_PIXEL && y < h) ? req_tdata[PB-1:0] : '0;
            base_in = req_tdata[2*PB-1:PB];

            for (int r = 0; r < 3; r++) begin
               win[r*3]   = win[r*3+1];
               win[r*3+1] = win[r*3+2];
            end
            win[2] = line_prev2[x];
            win[5] = line_prev[x];
            win[8] = pix;
            line_prev2[x] = line_prev[x];
            line_prev[x]  = pix;

            slot = n % (h + 1);
            acc = base_line[slot];
            base_line[slot] = base_in;

            col = x + 1;
            if (col == h) begin
               col = 0;
               row = y + 1;
            end

            if (n >= h + 1) begin
               m  = n - h - 1;
               mr = m / h;
               mc = m % h;
               up = mr > 0;
               dn = mr + 1 < h;
               lf = mc > 0;
               rt = mc + 1 < h;
               last = (m == h * h - 1);
               acc = blur_tap(acc, corner_w, win[0], lf && up);
               acc = blur_tap(acc, edge_w,   win[3], lf);
               acc = blur_tap(acc, corner_w, win[6], lf && dn);
               acc = blur_tap(acc, edge_w,   win[1], up);
               acc = blur_tap(acc, center_w, win[4], 1'b1);
               acc = blur_tap(acc, edge_w,   win[7], dn);
               acc = blur_tap(acc, corner_w, win[2], rt && up);
               acc = blur_tap(acc, edge_w,   win[5], rt);
               acc = blur_tap(acc, corner_w, win[8], rt && dn);
               expected_blur.push_back('{blurred: acc, last_pixel: last});
               if (last) restart_frame();
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_blur.size() == 0) begin
               $error("unexpected result item: blurred %0d last_pixel %0b",
                      $signed(rsp_tdata[PB-1:0]), rsp_tlast);
               fail_count++;
            end else begin
               want = expected_blur.pop_front();
               checked++;
               if (rsp_tdata[PB-1:0] !== want.blurred) begin
                  $error("blurred mismatch: expected %0d, actual %0d",
                         want.blurred, $signed(rsp_tdata[PB-1:0]));
                  fail_count++;
               end
               if (rsp_tlast !== want.last_pixel) begin
                  $error("last_pixel mismatch: expected %0b, actual %0b",
                         want.last_pixel, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_blur.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the blur accumulator testbench: clock, reset, CSR phases, image streams and
// random back-pressure. Depends on gb3_pkg, the RTL top and blur_checker.

module tb_top;
   import gb3_pkg::*;

   localparam int PB           = DEFAULT_PIXEL_BITS;
   localparam int MAX_W        = DEFAULT_MAX_WIDTH;
   localparam int REQ_BITS     = ((2*PB+7)/8)*8;
   localparam int RSP_BITS     = ((PB+7)/8)*8;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_BITS-1:0]          req_tdata  = '0;
   logic                         req_tuser  = OP_PIXEL;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]          rsp_tdata;
   logic                         rsp_tlast;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index  = REG_IMAGE_SIZE;
   logic [CSR_DATA_BITS-1:0]     csr_data   = '0;

   int  fail_count, pending, checked;
   int  cycle_count = 0;
   int  items_sent  = 0;
   int  images_done = 0;
   int  phase       = 0;
   int  ready_hold  = 0;
   int  rx_roll;
   bit  sender_free = 1'b0;
   bit  rx_free     = 1'b0;

   always #4 clock = ~clock;

   gaussian_blur_3x3_accumulate #(.MAX_WIDTH(MAX_W), .PIXEL_BITS(PB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   blur_checker #(.MAX_W(MAX_W), .PB(PB)) blur_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   // result side: runs of ready, short stalls, now and then a long one
   always @(posedge clock) begin
      if (rx_free) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rx_roll = $urandom_range(0, 99);
         if (rx_roll < 60) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
         end else if (rx_roll < 93) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [PB-1:0] rand_pixel();
      case ($urandom_range(0, 15))
         0: return {1'b0, {(PB-1){1'b1}}};
         1: return {1'b1, {(PB-1){1'b0}}};
         2: return '0;
         3: return '1;
         default: return PB'($urandom);
      endcase
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] rand_weight();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return '1;
         default: return WEIGHT_BITS'($urandom);
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input opcode_type op, input logic [PB-1:0] pix,
                            input logic [PB-1:0] base);
      int gap, roll;
      gap = 0;
      if (!sender_free) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) gap = $urandom_range(1, 3);
         else if (roll < 24) gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {base, pix};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // count items of a frame of size h; noisy frames get stray flushes and
   // pixel items during the drain
   task automatic send_image(input int unsigned h, input int unsigned count, input bit noisy);
      opcode_type op;
      for (int unsigned i = 0; i < count; i++) begin
         op = OP_PIXEL;
         if (i < h * h) begin
            if (noisy && $urandom_range(0, 99) < 4) op = OP_FLUSH;
         end else if (!(noisy && $urandom_range(0, 99) < 30)) begin
            op = OP_FLUSH;
         end
         send_item(op, rand_pixel(), rand_pixel());
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned          h, total, nimg, start_items;
      logic [SIZE_BITS-1:0] size_val;
      bit                   mid_image, huge, noisy;
      int                   roll;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 1x1 image (size 0 clamps to 1) with full weights: saturate both ways
      csr_write(REG_IMAGE_SIZE, '0);
      csr_write(REG_CORNER_WEIGHT, '1);
      csr_write(REG_EDGE_WEIGHT, '1);
      csr_write(REG_CENTER_WEIGHT, '1);
      send_item(OP_PIXEL, 16'h7fff, 16'h7fff);
      send_item(OP_FLUSH, 16'h1234, 16'h0000);
      send_item(OP_FLUSH, 16'h4321, 16'h0000);
      send_item(OP_PIXEL, 16'h8000, 16'h8000);
      send_item(OP_FLUSH, 16'hffff, 16'hffff);
      send_item(OP_FLUSH, 16'h0000, 16'hffff);
      wait_idle();

      // 2x2 with junk in the upper size bits, a flush inside the frame and a
      // pixel item during the drain
      csr_write(REG_IMAGE_SIZE, 16'hf802);
      csr_write(REG_CORNER_WEIGHT, '0);
      csr_write(REG_EDGE_WEIGHT, '1);
      csr_write(REG_CENTER_WEIGHT, 16'h8000);
      send_item(OP_PIXEL, 16'd1000, 16'd5);
      send_item(OP_FLUSH, 16'h7fff, 16'd7);
      send_item(OP_PIXEL, 16'hffff, 16'hfffd);
      send_item(OP_PIXEL, 16'h7fff, 16'd100);
      send_item(OP_PIXEL, 16'd12345, 16'd1);
      send_item(OP_FLUSH, 16'h0000, 16'h8000);
      send_item(OP_FLUSH, 16'h0000, 16'h7fff);
      wait_idle();

      // 3x3 with the power-on weights
      csr_write(REG_IMAGE_SIZE, 16'd3);
      csr_write(REG_CORNER_WEIGHT, CORNER_RESET);
      csr_write(REG_EDGE_WEIGHT, EDGE_RESET);
      csr_write(REG_CENTER_WEIGHT, CENTER_RESET);
      send_image(3, 13, 1'b0);
      images_done++;
      h = 3;
      mid_image = 1'b0;

      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         wait_idle();
         phase++;
         sender_free = ($urandom_range(0, 99) < 30);
         rx_free    <= ($urandom_range(0, 99) < 30);

         huge = (phase == 3);
         roll = $urandom_range(0, 99);
         // full width, either exactly or by a write of all ones that clamps
         if (huge)            size_val = ($urandom_range(0, 1) != 0) ? SIZE_BITS'(MAX_W) : '1;
         else if (roll < 60)  size_val = SIZE_BITS'($urandom_range(1, 6));
         else if (roll < 80)  size_val = SIZE_BITS'($urandom_range(7, 16));
         else if (roll < 86)  size_val = SIZE_BITS'($urandom_range(17, 24));
         else if (roll < 93)  size_val = '0;
         else                 size_val = SIZE_BITS'(1);

         if (mid_image || huge || $urandom_range(0, 99) < 75) begin
            csr_write(REG_IMAGE_SIZE, {5'($urandom), size_val});
            h = (size_val == 0) ? 1 : ((size_val > MAX_W) ? MAX_W : size_val);
            mid_image = 1'b0;
         end
         if ($urandom_range(0, 1)) csr_write(REG_CORNER_WEIGHT, rand_weight());
         if ($urandom_range(0, 1)) csr_write(REG_EDGE_WEIGHT, rand_weight());
         if ($urandom_range(0, 1)) csr_write(REG_CENTER_WEIGHT, rand_weight());

         if (huge) begin
            // only the first rows of a full-width frame, then the next size write restarts
            send_image(h, h + 21, 1'b1);
            mid_image = 1'b1;
         end else begin
            nimg = $urandom_range(1, 3);
            for (int k = 0; k < nimg && !mid_image; k++) begin
               noisy = ($urandom_range(0, 99) < 35);
               total = h * h + h + 1;
               if ($urandom_range(0, 99) < 10) begin
                  send_image(h, $urandom_range(1, total - 1), noisy);
                  mid_image = 1'b1;
               end else begin
                  send_image(h, total, noisy);
                  images_done++;
               end
            end
         end
      end

      wait_idle();
      $display("Run covered %0d items in %0d phases, %0d complete frames, %0d results checked",
               items_sent, phase, images_done, checked);
      $display("Frame sizes 1 to %0d with clamped writes, weights 0 to max, cut frames and noise",
               MAX_W);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
